### src/ttra_pkg.sv
// Shared types and constants for the traffic table with alarm-driven replacement.
`default_nettype none
package ttra_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] OP_REPORT = 2'd0;
  localparam logic [1:0] OP_SWEEP  = 2'd1;
  localparam logic [1:0] OP_SCAN   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_ZONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_SEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_EXPIRY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOUND_EXPIRY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SOUND_ENABLE = 3'd5;

  localparam logic [15:0] CLOSE_ZONE_RST   = 16'd10000;
  localparam logic [14:0] VERTICAL_SEP_RST = 15'd300;
  localparam logic [7:0]  ENTRY_EXPIRY_RST = 8'd5;
  localparam logic [7:0]  REFRESH_RST      = 8'd2;
  localparam logic [7:0]  SOUND_EXPIRY_RST = 8'd3;
  localparam logic        SOUND_ENABLE_RST = 1'b1;

  typedef struct packed {
    logic [23:0] id;
    logic [1:0]  alarm;
    logic [1:0]  alerted;
    logic [19:0] adj_range;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic expired;
    logic stale;
    logic audible;
  } age_t;

endpackage
`default_nettype wire

### src/ttra_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ttra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/ttra_age.sv
// Shared age unit: one 33-bit time difference checked against the three intervals.
`default_nettype none
module ttra_age (
  input  wire logic [31:0]     now,
  input  wire logic [31:0]     stamp,
  input  wire logic [7:0]      expiry,
  input  wire logic [7:0]      refresh,
  input  wire logic [7:0]      sound_win,
  output ttra_pkg::age_t       age
);
  import ttra_pkg::*;

  logic [32:0] diff;
  logic        pos;
  logic        big;

  assign diff = {1'b0, now} - {1'b0, stamp};
  assign pos  = ~diff[32];
  assign big  = diff[31:8] != 24'd0;

  assign age.expired = pos && (big || (diff[7:0] > expiry));
  assign age.stale   = pos && (big || (diff[7:0] >= refresh));
  assign age.audible = ~(pos && (big || (diff[7:0] > sound_win)));

endmodule
`default_nettype wire

### src/traffic_table_replace_alarm_core.sv
// Top level of the traffic table with alarm-driven replacement and sound scan.
//
// A word is taken when start is high and busy is low. The operation selects a
// traffic report, an update sweep or a sound scan. Every word produces exactly
// one result, shown for a single cycle while done is high; the receiver cannot
// stall, so the result must be captured in that cycle.
// For each word the sequencer reads one table entry per cycle from the entry
// RAM and passes it through the shared age unit; then the S_FINAL state
// decides and writes the chosen slot and the S_DONE state presents the
// result. busy stays high until the result cycle ends, so the next word can
// be taken in the cycle after done, not before.
// Configuration registers are written through cfg_valid/cfg_ready with an
// index and data; cfg_ready is always high and writes are meant for idle time.
// Reset restores the register defaults, marks every slot empty and clears the
// entry count and strobe level. Slots that are not marked occupied read as
// zero, so the RAM itself needs no clearing pass.
`default_nettype none
module traffic_table_replace_alarm_core #(
  parameter int TABLE_DEPTH = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  output logic                                    done,
  input  wire logic [1:0]                         operation,
  input  wire logic [31:0]                        now_s,
  input  wire logic [23:0]                        report_id,
  input  wire logic [1:0]                         report_alarm,
  input  wire logic [15:0]                        report_distance,
  input  wire logic signed [15:0]                 report_vertical,
  input  wire logic [19:0]                        report_adj_dist,
  output logic                                    report_stored,
  output logic [2:0]                              report_slot,
  output logic [1:0]                              sound_level,
  output logic [1:0]                              strobe_level,
  output logic [3:0]                              occupancy,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ttra_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ttra_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ttra_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(entry_t);
  localparam logic [AW:0] DEPTH_C = (AW + 1)'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOP  = 2'd1;
  localparam logic [1:0] S_FINAL = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]             state;
  logic [TABLE_DEPTH-1:0] occ;
  logic [CW-1:0]          cnt;
  logic [1:0]             max_alarm_seen;
  logic [AW:0]            rd_cnt;
  logic                   ev_valid;
  logic [AW-1:0]          ev_idx;

  logic [15:0] close_zone_m;
  logic [14:0] vertical_sep_m;
  logic [7:0]  entry_expiry_s;
  logic [7:0]  refresh_interval_s;
  logic [7:0]  sound_expiry_s;
  logic        sound_enable;

  logic [1:0]  op_q;
  logic [31:0] now_q;
  logic [23:0] rid_q;
  logic [1:0]  ralarm_q;
  logic [19:0] radj_q;
  logic        drop_q;

  logic          match_found;
  logic [AW-1:0] match_k;
  logic [1:0]    match_alerted;
  logic          free_found;
  logic [AW-1:0] free_k;
  logic [19:0]   far_d;
  logic [AW-1:0] far_k;
  logic [1:0]    far_alarm;
  logic          low_set;
  logic [AW-1:0] low_k;
  logic [1:0]    low_alarm;
  logic [19:0]   low_d;
  logic [1:0]    max_acc;
  logic [1:0]    snd;
  logic [AW-1:0] pick_k;
  logic [23:0]   pick_id;
  logic [1:0]    pick_alarm;
  logic [19:0]   pick_adj;

  logic [EW-1:0] rd_word;
  logic [AW-1:0] rd_addr;
  entry_t        ent;
  logic          ent_occ;
  age_t          age;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;

  logic          sweep_we;
  logic          sweep_clr;
  entry_t        sweep_word;
  logic          fin_we;
  logic [AW-1:0] fin_k;
  entry_t        fin_word;
  entry_t        new_word;

  logic [16:0] vabs;
  logic        drop_in;
  logic [31:0] slot_ext;
  logic [31:0] cnt_ext;

  assign cfg_ready = 1'b1;
  assign busy      = state != S_IDLE;
  assign done      = state == S_DONE;

  assign rd_addr = rd_cnt[AW-1:0];
  assign ent_occ = occ[ev_idx];
  assign ent     = ent_occ ? entry_t'(rd_word) : '0;

  ttra_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_addr),
    .rdata(rd_word)
  );

  ttra_age u_age (
    .now      (now_q),
    .stamp    (ent.stamp),
    .expiry   (entry_expiry_s),
    .refresh  (refresh_interval_s),
    .sound_win(sound_expiry_s),
    .age      (age)
  );

  assign vabs = report_vertical[15] ? (17'd0 - {1'b1, report_vertical})
                                    : {1'b0, report_vertical};
  assign drop_in = (report_id == 24'd0) ||
                   ((report_alarm == 2'd0) &&
                    ((report_distance > close_zone_m) || (vabs > {2'b00, vertical_sep_m})));

  always_comb begin
    sweep_clr  = ev_valid && (op_q == OP_SWEEP) && ent_occ && age.expired;
    sweep_we   = ev_valid && (op_q == OP_SWEEP) && ent_occ &&
                 (age.expired || (age.stale && (ent.alarm < ent.alerted)));
    sweep_word = ent;
    sweep_word.alerted = ent.alarm;
    if (sweep_clr) begin
      sweep_word = '0;
    end
  end

  always_comb begin
    new_word.id        = rid_q;
    new_word.alarm     = ralarm_q;
    new_word.alerted   = 2'd0;
    new_word.adj_range = radj_q;
    new_word.stamp     = now_q;
    fin_we   = 1'b0;
    fin_k    = '0;
    fin_word = new_word;
    if ((op_q == OP_REPORT) && !drop_q) begin
      priority if (match_found) begin
        fin_we           = 1'b1;
        fin_k            = match_k;
        fin_word.alerted = match_alerted;
      end else if (free_found) begin
        fin_we = 1'b1;
        fin_k  = free_k;
      end else if (ralarm_q > low_alarm) begin
        fin_we = 1'b1;
        fin_k  = low_k;
      end else if ((radj_q < far_d) && (ralarm_q >= far_alarm)) begin
        fin_we = 1'b1;
        fin_k  = far_k;
      end
    end else if ((op_q == OP_SCAN) && sound_enable && (snd != 2'd0)) begin
      fin_we             = 1'b1;
      fin_k              = pick_k;
      fin_word.id        = pick_id;
      fin_word.alarm     = pick_alarm;
      fin_word.alerted   = snd;
      fin_word.adj_range = pick_adj;
      fin_word.stamp     = now_q;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ev_idx;
    ram_wdata = sweep_word;
    if (state == S_LOOP) begin
      ram_we = sweep_we;
    end else if (state == S_FINAL) begin
      ram_we    = fin_we;
      ram_waddr = fin_k;
      ram_wdata = fin_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      occ                <= '0;
      cnt                <= '0;
      max_alarm_seen     <= 2'd0;
      rd_cnt             <= '0;
      ev_valid           <= 1'b0;
      close_zone_m       <= CLOSE_ZONE_RST;
      vertical_sep_m     <= VERTICAL_SEP_RST;
      entry_expiry_s     <= ENTRY_EXPIRY_RST;
      refresh_interval_s <= REFRESH_RST;
      sound_expiry_s     <= SOUND_EXPIRY_RST;
      sound_enable       <= SOUND_ENABLE_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_CLOSE_ZONE:   close_zone_m       <= cfg_data;
          REG_VERTICAL_SEP: vertical_sep_m     <= cfg_data[14:0];
          REG_ENTRY_EXPIRY: entry_expiry_s     <= cfg_data[7:0];
          REG_REFRESH:      refresh_interval_s <= cfg_data[7:0];
          REG_SOUND_EXPIRY: sound_expiry_s     <= cfg_data[7:0];
          REG_SOUND_ENABLE: sound_enable       <= cfg_data[0];
          default: begin
          end
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state    <= S_LOOP;
            rd_cnt   <= '0;
            ev_valid <= 1'b0;
          end
        end
        S_LOOP: begin
          if (rd_cnt != DEPTH_C) begin
            rd_cnt   <= rd_cnt + (AW + 1)'(1);
            ev_valid <= 1'b1;
          end else begin
            ev_valid <= 1'b0;
            if (!ev_valid) begin
              state <= S_FINAL;
            end
          end
          if (sweep_clr) begin
            occ[ev_idx] <= 1'b0;
            cnt         <= cnt - CW'(1);
          end
        end
        S_FINAL: begin
          if (fin_we) begin
            occ[fin_k] <= 1'b1;
            if (!occ[fin_k]) begin
              cnt <= cnt + CW'(1);
            end
          end
          if ((op_q == OP_SCAN) && sound_enable) begin
            max_alarm_seen <= max_acc;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign slot_ext = 32'(fin_k);

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      op_q        <= operation;
      now_q       <= now_s;
      rid_q       <= report_id;
      ralarm_q    <= report_alarm;
      radj_q      <= report_adj_dist;
      drop_q      <= drop_in;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      far_d       <= 20'd0;
      far_k       <= '0;
      far_alarm   <= 2'd0;
      low_set     <= 1'b0;
      max_acc     <= 2'd0;
      snd         <= 2'd0;
      pick_k      <= '0;
    end
    if (state == S_LOOP) begin
      ev_idx <= rd_addr;
    end
    if ((state == S_LOOP) && ev_valid) begin
      if (op_q == OP_REPORT) begin
        if (!match_found && ent_occ && (ent.id == rid_q)) begin
          match_found   <= 1'b1;
          match_k       <= ev_idx;
          match_alerted <= ent.alerted;
        end
        if (!free_found) begin
          if (!ent_occ || age.expired) begin
            free_found <= 1'b1;
            free_k     <= ev_idx;
          end else begin
            if (ent.adj_range > far_d) begin
              far_d     <= ent.adj_range;
              far_k     <= ev_idx;
              far_alarm <= ent.alarm;
            end
            if (!low_set || (ent.alarm < low_alarm) ||
                ((ent.alarm == low_alarm) && (ent.adj_range > low_d))) begin
              low_set   <= 1'b1;
              low_k     <= ev_idx;
              low_alarm <= ent.alarm;
              low_d     <= ent.adj_range;
            end
          end
        end
      end else if (op_q == OP_SCAN) begin
        if (ent_occ && age.audible) begin
          if (ent.alarm > max_acc) begin
            max_acc <= ent.alarm;
          end
          if ((ent.alarm > snd) && (ent.alarm > ent.alerted)) begin
            snd        <= ent.alarm;
            pick_k     <= ev_idx;
            pick_id    <= ent.id;
            pick_alarm <= ent.alarm;
            pick_adj   <= ent.adj_range;
          end
        end
      end
    end
    if (state == S_FINAL) begin
      report_stored <= (op_q == OP_REPORT) && fin_we;
      report_slot   <= ((op_q == OP_REPORT) && fin_we) ? slot_ext[2:0] : 3'd0;
      sound_level   <= ((op_q == OP_SCAN) && sound_enable) ? snd : 2'd0;
    end
  end

  assign cnt_ext      = 32'(cnt);
  assign occupancy    = cnt_ext[3:0];
  assign strobe_level = max_alarm_seen;

endmodule
`default_nettype wire
